/* design/drift_cell_double_hit_digitizer_assert.svh */
// Assertion macros for the drift cell digitizer checker.
// Used by the bound checker module; no other dependencies.
`ifndef DRIFT_CELL_DOUBLE_HIT_DIGITIZER_ASSERT_SVH
`define DRIFT_CELL_DOUBLE_HIT_DIGITIZER_ASSERT_SVH

// same-cycle implication
`define DCDHD_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DCDHD_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

/* design/dcdhd_pkg.sv */
// Shared types and constants of the drift cell double-hit digitizer.
// No dependencies.
package dcdhd_pkg;

	typedef struct packed {
		logic signed [31:0] tm;
		logic [23:0]        trk;
	} hit_entry_t;

	typedef struct packed {
		logic [23:0] distance_scale;
		logic [23:0] low_edge;
		logic [23:0] high_edge;
		logic [23:0] low_curvature;
		logic [23:0] base_resolution;
		logic [23:0] high_curvature;
		logic [23:0] inverse_drift_velocity;
		logic [16:0] efficiency_threshold;
	} cfg_regs_t;

	typedef enum logic [2:0] {
		REG_DISTANCE_SCALE   = 3'd0,
		REG_LOW_EDGE         = 3'd1,
		REG_HIGH_EDGE        = 3'd2,
		REG_LOW_CURVATURE    = 3'd3,
		REG_BASE_RESOLUTION  = 3'd4,
		REG_HIGH_CURVATURE   = 3'd5,
		REG_INV_DRIFT_VEL    = 3'd6,
		REG_EFF_THRESHOLD    = 3'd7
	} reg_index_t;

	// smear divisor 10000 * 2^12 = 2^16 * 625; 625 done by reciprocal
	localparam int unsigned SMEAR_RND   = 20480000;
	localparam int unsigned SMEAR_RECIP = 27487791;
	localparam int unsigned SMEAR_SHIFT = 34;
	// separation = (idv + 100) / 200 = ((idv + 100) >> 3) / 25
	localparam int unsigned SEP_RND     = 100;
	localparam int unsigned SEP_RECIP   = 5368710;
	localparam int unsigned SEP_SHIFT   = 27;
	localparam int unsigned CALC_STAGES = 11;

endpackage

/* design/dcdhd_if.sv */
// Channel interfaces: configuration write, hit input, result output.
// Depends on nothing beyond plain logic types.
interface dcdhd_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [23:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

interface dcdhd_hit_if;
	logic               valid;
	logic               ready;
	logic [23:0]        min_distance;
	logic signed [31:0] flight_time;
	logic [23:0]        track_number;
	logic signed [15:0] gauss_sample;
	logic [15:0]        uniform_sample;
	logic               last_hit;
	modport source(output valid, min_distance, flight_time, track_number, gauss_sample,
		uniform_sample, last_hit, input ready);
	modport sink(input valid, min_distance, flight_time, track_number, gauss_sample,
		uniform_sample, last_hit, output ready);
endinterface

interface dcdhd_res_if;
	logic               valid;
	logic               ready;
	logic [1:0]         hit_multiplicity;
	logic signed [31:0] time_first;
	logic [23:0]        track_first;
	logic signed [31:0] time_second;
	logic [23:0]        track_second;
	logic               status_code;
	logic               overflow;
	modport source(output valid, hit_multiplicity, time_first, track_first, time_second,
		track_second, status_code, overflow, input ready);
	modport sink(input valid, hit_multiplicity, time_first, track_first, time_second,
		track_second, status_code, overflow, output ready);
endinterface

/* design/dcdhd_time_calc.sv */
// Drift time pipeline: scaled distance, resolution, smear, time.
// Depends on dcdhd_pkg. Inputs must stay stable until done.
module dcdhd_time_calc (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  dcdhd_pkg::cfg_regs_t   regs,
	input  logic [23:0]            min_dist,
	input  logic signed [31:0]     tof,
	input  logic signed [15:0]     gauss,
	output logic                   done,
	output logic signed [31:0]     tm
);
	logic [dcdhd_pkg::CALC_STAGES:0] v_q;

	logic [47:0] p1;
	logic [48:0] p1r;
	logic [23:0] di_s1;
	logic [23:0] delta_c, curv_c, delta_s2, curv_s2, curv_s3, res_s5;
	logic [47:0] sq;
	logic [48:0] sqr;
	logic [31:0] sq_s3;
	logic [55:0] tp;
	logic [56:0] tpr;
	logic [40:0] term_s4;
	logic [41:0] rsum;
	logic signed [40:0] prod_s6;
	logic [40:0] mag7, ysum;
	logic [24:0] y_s7;
	logic        neg_s7;
	logic [50:0] qp;
	logic [16:0] q8;
	logic signed [17:0] smear_s8;
	logic signed [25:0] len_s9;
	logic signed [50:0] p2_s10;
	logic [50:0] mag2, m2r;
	logic [34:0] q2;
	logic signed [35:0] sq2;
	logic signed [37:0] tsum;
	logic signed [31:0] tm_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else         v_q <= {v_q[dcdhd_pkg::CALC_STAGES-1:0], start};
	end
	assign done = v_q[dcdhd_pkg::CALC_STAGES];
	assign tm   = tm_s11;

	assign p1  = min_dist * regs.distance_scale;
	assign p1r = {1'b0, p1} + 49'h8000;

	always_comb begin
		delta_c = '0;
		curv_c  = '0;
		if (di_s1 <= regs.low_edge) begin
			delta_c = regs.low_edge - di_s1;
			curv_c  = regs.low_curvature;
		end else if (di_s1 >= regs.high_edge) begin
			delta_c = di_s1 - regs.high_edge;
			curv_c  = regs.high_curvature;
		end
	end

	assign sq   = delta_s2 * delta_s2;
	assign sqr  = {1'b0, sq} + 49'h8000;
	assign tp   = sq_s3 * curv_s3;
	assign tpr  = {1'b0, tp} + 57'h8000;
	assign rsum = {1'b0, term_s4} + {18'b0, regs.base_resolution};
	assign mag7 = prod_s6[40] ? 41'(-prod_s6) : 41'(prod_s6);
	assign ysum = mag7 + 41'(dcdhd_pkg::SMEAR_RND);
	assign qp   = {26'b0, y_s7} * {25'b0, 26'(dcdhd_pkg::SMEAR_RECIP)};
	assign q8   = qp[dcdhd_pkg::SMEAR_SHIFT +: 17];
	assign mag2 = p2_s10[50] ? 51'(-p2_s10) : 51'(p2_s10);
	assign m2r  = mag2 + 51'h8000;
	assign q2   = m2r[50:16];
	assign sq2  = p2_s10[50] ? -$signed({1'b0, q2}) : $signed({1'b0, q2});
	assign tsum = 38'(sq2) + 38'(tof);

	always_ff @(posedge clk) begin
		di_s1    <= (|p1r[48:40]) ? 24'hFFFFFF : p1r[39:16];
		delta_s2 <= delta_c;
		curv_s2  <= curv_c;
		sq_s3    <= sqr[47:16];
		curv_s3  <= curv_s2;
		term_s4  <= tpr[56:16];
		res_s5   <= (|rsum[41:24]) ? 24'hFFFFFF : rsum[23:0];
		prod_s6  <= $signed({1'b0, res_s5}) * gauss;
		y_s7     <= ysum[40:16];
		neg_s7   <= prod_s6[40];
		smear_s8 <= neg_s7 ? -$signed({1'b0, q8}) : $signed({1'b0, q8});
		len_s9   <= $signed({2'b0, min_dist}) + 26'(smear_s8);
		p2_s10   <= len_s9 * $signed({1'b0, regs.inverse_drift_velocity});
		if (tsum > 38'sd2147483647)       tm_s11 <= 32'sh7FFFFFFF;
		else if (tsum < -38'sd2147483648) tm_s11 <= 32'sh80000000;
		else                              tm_s11 <= tsum[31:0];
	end
endmodule

/* design/dcdhd_cell.sv */
// One storage cell of the hit ring: loads a new hit or takes its neighbor.
// Depends on dcdhd_pkg.
module dcdhd_cell (
	input  logic                  clk,
	input  logic                  load_en,
	input  logic                  shift_en,
	input  dcdhd_pkg::hit_entry_t load_data,
	input  dcdhd_pkg::hit_entry_t nbr,
	output dcdhd_pkg::hit_entry_t q
);
	dcdhd_pkg::hit_entry_t ent_q;

	always_ff @(posedge clk) begin
		if (load_en)       ent_q <= load_data;
		else if (shift_en) ent_q <= nbr;
	end
	assign q = ent_q;
endmodule

/* design/drift_cell_double_hit_digitizer.sv */
// Top level of the drift cell double-hit digitizer: config, ring of cells, sort.
// Depends on dcdhd_pkg, dcdhd_if, dcdhd_time_calc, dcdhd_cell.
//
//  channel | dir | handshake     | payload
//  cfg     | in  | valid/ready   | index, data
//  hit     | in  | valid/ready   | one hit of the cell
//  res     | out | valid/ready   | resolved times, tracks, status, overflow
//
// A stored hit runs through the time pipeline and is then written to its cell;
// a dropped hit skips both. The last hit then starts n ring revolutions
// (n = stored hits): n-1 selection passes, then one pass that picks the outputs.
// Reset clears count, flags and the result valid bit; cells hold no reset.
// The result register lets the next hit in while the last result waits.
module drift_cell_double_hit_digitizer #(
	parameter int MAX_HITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	dcdhd_cfg_if.sink     cfg,
	dcdhd_hit_if.sink     hit,
	dcdhd_res_if.source   res
);
	localparam int CNT_W = $clog2(MAX_HITS + 1);
	localparam int POS_W = $clog2(MAX_HITS);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CALC = 4'b0010,
		ST_SORT = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t                state_q;
	dcdhd_pkg::cfg_regs_t  regs_q;
	logic [CNT_W-1:0]      count_q;
	logic                  ineff_q, ovf_q;
	logic [23:0]           dist_q, trk_q;
	logic signed [31:0]    tof_q;
	logic signed [15:0]    gauss_q;
	logic                  last_q;
	logic                  hit_fire, calc_start, calc_done, room;
	logic signed [31:0]    calc_tm;
	dcdhd_pkg::hit_entry_t cell_q [MAX_HITS];
	dcdhd_pkg::hit_entry_t head_eff, new_ent;

	logic [POS_W-1:0]      pos_q, pass_q, sw_a_q, sw_c_q, cur_c_q, nxt_c;
	logic                  sw_v_q, found_q;
	dcdhd_pkg::hit_entry_t sw_aval_q, sw_min_q, cur_q, aval_q, nxt_cur, nxt_aval;
	dcdhd_pkg::hit_entry_t first_q, second_q;
	logic signed [31:0]    prev_q;
	logic [24:0]           sep_x;
	logic [44:0]           sep_p;
	logic [16:0]           sep_q;
	logic                  in_range, last_pass, rev_end, sep_hit;
	logic signed [32:0]    tdiff;

	logic [1:0]            o_mult_q;
	dcdhd_pkg::hit_entry_t o_first_q, o_second_q;
	logic                  o_stat_q, o_ovf_q, o_v_q, out_load;

	// configuration
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.distance_scale         <= 24'd65536;
			regs_q.low_edge               <= 24'd0;
			regs_q.high_edge              <= 24'hFFFFFF;
			regs_q.low_curvature          <= 24'd0;
			regs_q.base_resolution        <= 24'd0;
			regs_q.high_curvature         <= 24'd0;
			regs_q.inverse_drift_velocity <= 24'd65536;
			regs_q.efficiency_threshold   <= 17'd65536;
		end else if (cfg.valid) begin
			case (dcdhd_pkg::reg_index_t'(cfg.index))
				dcdhd_pkg::REG_DISTANCE_SCALE:  regs_q.distance_scale <= cfg.data;
				dcdhd_pkg::REG_LOW_EDGE:        regs_q.low_edge <= cfg.data;
				dcdhd_pkg::REG_HIGH_EDGE:       regs_q.high_edge <= cfg.data;
				dcdhd_pkg::REG_LOW_CURVATURE:   regs_q.low_curvature <= cfg.data;
				dcdhd_pkg::REG_BASE_RESOLUTION: regs_q.base_resolution <= cfg.data;
				dcdhd_pkg::REG_HIGH_CURVATURE:  regs_q.high_curvature <= cfg.data;
				dcdhd_pkg::REG_INV_DRIFT_VEL:   regs_q.inverse_drift_velocity <= cfg.data;
				dcdhd_pkg::REG_EFF_THRESHOLD:   regs_q.efficiency_threshold <= cfg.data[16:0];
				default: ;
			endcase
		end
	end

	// separation threshold, refreshed every cycle from the register
	assign sep_x = {1'b0, regs_q.inverse_drift_velocity} + 25'(dcdhd_pkg::SEP_RND);
	assign sep_p = sep_x[24:3] * 23'(dcdhd_pkg::SEP_RECIP);
	always_ff @(posedge clk) sep_q <= sep_p[dcdhd_pkg::SEP_SHIFT +: 17];

	assign hit.ready  = (state_q == ST_IDLE);
	assign hit_fire   = hit.valid && hit.ready;
	assign room       = (count_q < CNT_W'(MAX_HITS));
	assign calc_start = hit_fire && room;

	always_ff @(posedge clk) begin
		if (hit_fire) begin
			dist_q  <= hit.min_distance;
			tof_q   <= hit.flight_time;
			trk_q   <= hit.track_number;
			gauss_q <= hit.gauss_sample;
			last_q  <= hit.last_hit;
		end
	end

	dcdhd_time_calc u_calc (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (calc_start),
		.regs     (regs_q),
		.min_dist (dist_q),
		.tof      (tof_q),
		.gauss    (gauss_q),
		.done     (calc_done),
		.tm       (calc_tm)
	);

	assign new_ent.tm  = calc_tm;
	assign new_ent.trk = trk_q;

	// head of the ring, with the previous pass's swap applied on the fly
	always_comb begin
		head_eff = cell_q[0];
		if (sw_v_q && pos_q == sw_c_q)      head_eff = sw_aval_q;
		else if (sw_v_q && pos_q == sw_a_q) head_eff = sw_min_q;
	end

	genvar gi;
	generate
		for (gi = 0; gi < MAX_HITS; gi++) begin : g_cell
			dcdhd_cell u_cell (
				.clk       (clk),
				.load_en   (state_q == ST_CALC && calc_done &&
				            count_q[POS_W-1:0] == POS_W'(gi)),
				.shift_en  (state_q == ST_SORT),
				.load_data (new_ent),
				.nbr       ((gi == MAX_HITS - 1) ? head_eff : cell_q[(gi + 1) % MAX_HITS]),
				.q         (cell_q[gi])
			);
		end
	endgenerate

	assign in_range  = (CNT_W'(pos_q) < count_q);
	assign last_pass = (CNT_W'(pass_q) + CNT_W'(1) == count_q);
	assign rev_end   = (pos_q == POS_W'(MAX_HITS - 1));
	assign tdiff     = 33'(head_eff.tm) - 33'(prev_q);
	assign sep_hit   = (tdiff >= $signed({16'b0, sep_q}));

	// selection pass: minimum over positions pass..n-1 as the ring goes by
	always_comb begin
		nxt_cur  = cur_q;
		nxt_c    = cur_c_q;
		nxt_aval = aval_q;
		if (pos_q == pass_q) begin
			nxt_cur  = head_eff;
			nxt_c    = pos_q;
			nxt_aval = head_eff;
		end else if (pos_q > pass_q && in_range && head_eff.tm < cur_q.tm) begin
			nxt_cur = head_eff;
			nxt_c   = pos_q;
		end
	end

	assign out_load = (state_q == ST_DONE) && (!o_v_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			ineff_q <= 1'b0;
			ovf_q   <= 1'b0;
			pos_q   <= '0;
			pass_q  <= '0;
			sw_v_q  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (hit_fire) begin
						ineff_q <= {1'b0, hit.uniform_sample} > regs_q.efficiency_threshold;
						if (!room) ovf_q <= 1'b1;
						pos_q   <= '0;
						pass_q  <= '0;
						sw_v_q  <= 1'b0;
						found_q <= 1'b0;
						if (room)               state_q <= ST_CALC;
						else if (hit.last_hit)  state_q <= ST_SORT;
					end
				end
				ST_CALC: begin
					if (calc_done) begin
						count_q <= count_q + CNT_W'(1);
						state_q <= last_q ? ST_SORT : ST_IDLE;
					end
				end
				ST_SORT: begin
					pos_q <= rev_end ? '0 : pos_q + POS_W'(1);
					if (last_pass) begin
						if (pos_q != '0 && in_range && !found_q && sep_hit) found_q <= 1'b1;
						if (rev_end) state_q <= ST_DONE;
					end else if (rev_end) begin
						sw_v_q <= (nxt_c != pass_q);
						pass_q <= pass_q + POS_W'(1);
					end
				end
				ST_DONE: begin
					if (out_load) begin
						count_q <= '0;
						ineff_q <= 1'b0;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// sort datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_SORT) begin
			if (last_pass) begin
				if (pos_q == '0) first_q <= head_eff;
				if (pos_q != '0 && in_range && !found_q && sep_hit) second_q <= head_eff;
				prev_q <= head_eff.tm;
			end else begin
				cur_q   <= nxt_cur;
				cur_c_q <= nxt_c;
				aval_q  <= nxt_aval;
				if (rev_end) begin
					sw_a_q    <= pass_q;
					sw_c_q    <= nxt_c;
					sw_aval_q <= nxt_aval;
					sw_min_q  <= nxt_cur;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)        o_v_q <= 1'b0;
		else if (out_load)  o_v_q <= 1'b1;
		else if (res.ready) o_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_mult_q   <= found_q ? 2'd2 : 2'd1;
			o_first_q  <= first_q;
			o_second_q <= found_q ? second_q : '0;
			o_stat_q   <= ineff_q;
			o_ovf_q    <= ovf_q;
		end
	end

	assign res.valid            = o_v_q;
	assign res.hit_multiplicity = o_mult_q;
	assign res.time_first       = o_first_q.tm;
	assign res.track_first      = o_first_q.trk;
	assign res.time_second      = o_second_q.tm;
	assign res.track_second     = o_second_q.trk;
	assign res.status_code      = o_stat_q;
	assign res.overflow         = o_ovf_q;
endmodule

/* design/dcdhd_checker.sv */
// Port-level checker for the drift cell digitizer, bound to the top level.
// Depends on drift_cell_double_hit_digitizer_assert.svh.
`include "drift_cell_double_hit_digitizer_assert.svh"

module dcdhd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_ready,
	input logic [1:0]         hit_mult,
	input logic signed [31:0] time_second,
	input logic [23:0]        track_second
);
	`DCDHD_ASSERT_NOW(a_mult_legal, clk, arst_n, res_valid, (hit_mult == 2'd1 || hit_mult == 2'd2), "multiplicity out of range")
	`DCDHD_ASSERT_NOW(a_single_zero, clk, arst_n, res_valid && hit_mult == 2'd1, (time_second == 32'sd0 && track_second == 24'd0), "second hit not zero")
	`DCDHD_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid, "result dropped while stalled")
	`DCDHD_ASSERT_NEXT(a_res_stable, clk, arst_n, res_valid && !res_ready, ($stable(hit_mult) && $stable(time_second) && $stable(track_second)), "result changed while stalled")
endmodule

bind drift_cell_double_hit_digitizer dcdhd_checker u_dcdhd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.hit_mult     (res.hit_multiplicity),
	.time_second  (res.time_second),
	.track_second (res.track_second)
);
